/* hw/rtl/btda_pkg.sv */
// Shared constants, types and helpers for the binary to decimal ASCII converter.
// The front, queue, back and top level files all use this package.
`timescale 1ns / 1ps

package btda_pkg;

  localparam int VALUE_W      = 32;
  localparam int MAX_DIGITS   = 10;
  localparam int BCD_W        = MAX_DIGITS * 4;
  localparam int BITS_PER_CYC = 4;
  localparam int CONV_CYCLES  = VALUE_W / BITS_PER_CYC;
  localparam int CNT_W        = (CONV_CYCLES > 1) ? $clog2(CONV_CYCLES) : 1;
  localparam int IDX_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;
  localparam int DIGIT_W      = 6;
  localparam int TDATA_IN_W   = 32;
  localparam int TDATA_OUT_W  = 8;

  localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

  // One converted number: packed BCD digits and the position of the top digit
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [IDX_W-1:0] top;
  } word_t;

  // Occupancy flags of the queue seen by both of its neighbours
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // One shift-add-3 step: correct every digit of five or more, then shift in din
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic din);
    logic [BCD_W-1:0] adj;
    logic [3:0]       d;
    adj = bcd;
    for (int n = 0; n < MAX_DIGITS; n++) begin
      d = bcd[n*4 +: 4];
      if (d >= 4'd5) begin
        adj[n*4 +: 4] = d + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], din};
  endfunction

  // Position of the highest non-zero digit, zero if all digits are zero
  function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] top;
    top = '0;
    for (int n = 0; n < MAX_DIGITS; n++) begin
      if (bcd[n*4 +: 4] != 4'd0) begin
        top = IDX_W'(n);
      end
    end
    return top;
  endfunction

endpackage

/* hw/rtl/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter.
// Depends on btda_pkg, btda_convert, btda_queue and btda_emit.
//
// Usage:
//   Input stream (s_axis_*): one transfer carries one unsigned 32-bit number.
//   Output stream (m_axis_*): one transfer per decimal digit, most significant
//   first, ASCII '0' to '9', leading zeros suppressed; zero gives a lone '0'.
//   m_axis_tlast marks the final, least significant digit of each number.
//   The first digit follows the input transfer through the shift-add-3
//   conversion, the push into the queue and the load of the digit walker.
//   The converter takes a new number only once the last one is converted, as
//   it pushes that one into the queue; the output side sends one digit per
//   cycle while m_axis_tready is high. The two-entry queue lets the
//   converter run ahead while the receiver stalls.
//   Reset: all control state clears; nothing is pending afterwards.
//   Stall: with m_axis_tready low the digit on show holds; s_axis_tready is
//   low while a conversion runs and stays low after it while the queue is full.
`timescale 1ns / 1ps

module binary_to_decimal_ascii (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [btda_pkg::TDATA_IN_W-1:0]      s_axis_tdata,   // [31:0] value
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [btda_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,   // [5:0] ascii_digit, [7:6] zero
  output logic                                 m_axis_tlast    // last_digit
);

  logic                               push, pop;
  btda_pkg::word_t                    push_word, head;
  btda_pkg::queue_status_t            q_status;
  logic [btda_pkg::DIGIT_W-1:0]       digit;

  // Front: take numbers in and convert them to BCD
  btda_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata[btda_pkg::VALUE_W-1:0]),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_word_o (push_word)
  );

  // Hold finished words until the digit walker is free
  btda_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Back: send digits from the top non-zero one down to the units digit
  btda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_digit_o (digit),
    .out_last_o  (m_axis_tlast)
  );

  // Pad the digit up to a whole byte
  assign m_axis_tdata = {(btda_pkg::TDATA_OUT_W - btda_pkg::DIGIT_W)'(0), digit};

endmodule

/* hw/rtl/btda_convert.sv */
// Front end: accepts a binary value and converts it to packed BCD by shift-add-3.
// Uses btda_pkg; pushes each finished word into btda_queue.
`timescale 1ns / 1ps

module btda_convert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [btda_pkg::VALUE_W-1:0]    in_value_i,
  input  btda_pkg::queue_status_t         q_status_i,
  output logic                            push_o,
  output btda_pkg::word_t                 push_word_o
);

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_RUN  = 3'b010,
    CV_DONE = 3'b100
  } conv_state_e;

  conv_state_e                      state_q, state_d;
  logic [btda_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [btda_pkg::VALUE_W-1:0]     bin_q, bin_d, bin_n;
  logic [btda_pkg::BCD_W-1:0]       bcd_q, bcd_d, bcd_n;
  logic                             accept;

  // Four shift-add-3 steps per cycle
  always_comb begin
    bcd_n = bcd_q;
    bin_n = bin_q;
    for (int k = 0; k < btda_pkg::BITS_PER_CYC; k++) begin
      bcd_n = btda_pkg::dabble_step(bcd_n, bin_n[btda_pkg::VALUE_W-1]);
      bin_n = {bin_n[btda_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  assign push_o           = (state_q == CV_DONE) && !q_status_i.full;
  assign in_ready_o       = (state_q == CV_IDLE) || push_o;
  assign accept           = in_valid_i && in_ready_o;
  assign push_word_o.bcd  = bcd_q;
  assign push_word_o.top  = btda_pkg::top_digit(bcd_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    case (state_q)
      CV_IDLE: begin
        if (accept) begin
          state_d = CV_RUN;
        end
      end
      CV_RUN: begin
        bin_d = bin_n;
        bcd_d = bcd_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == btda_pkg::CNT_W'(btda_pkg::CONV_CYCLES - 1)) begin
          state_d = CV_DONE;
        end
      end
      CV_DONE: begin
        if (accept) begin
          state_d = CV_RUN;
        end else if (push_o) begin
          state_d = CV_IDLE;
        end
      end
      default: state_d = CV_IDLE;
    endcase
    // Load a fresh value whenever one is taken in
    if (accept) begin
      bin_d = in_value_i;
      bcd_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

/* hw/rtl/btda_queue.sv */
// Two-entry queue of converted words between the front and back ends.
// Uses btda_pkg for the word type and status struct.
`timescale 1ns / 1ps

module btda_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  btda_pkg::word_t          push_word_i,
  input  logic                     pop_i,
  output btda_pkg::word_t          head_o,
  output btda_pkg::queue_status_t  status_o
);

  btda_pkg::word_t                  mem_q [btda_pkg::QUEUE_DEPTH];
  logic [btda_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [btda_pkg::QCNT_W-1:0]      count_q, count_d;

  assign status_o.full  = (count_q == btda_pkg::QCNT_W'(btda_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

/* hw/rtl/btda_emit.sv */
// Back end: walks a converted word from its top digit down, one ASCII digit a transfer.
// Uses btda_pkg; pops words from btda_queue.
`timescale 1ns / 1ps

module btda_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  btda_pkg::word_t                 head_i,
  input  btda_pkg::queue_status_t         q_status_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [btda_pkg::DIGIT_W-1:0]    out_digit_o,
  output logic                            out_last_o
);

  logic                             busy_q;
  logic [btda_pkg::IDX_W-1:0]       idx_q;
  logic [btda_pkg::BCD_W-1:0]       bcd_q;
  logic                             xfer;
  logic [3:0]                       digit;

  assign xfer        = busy_q && out_ready_i;
  assign out_last_o  = (idx_q == '0);
  assign pop_o       = !q_status_i.empty && (!busy_q || (xfer && out_last_o));
  assign out_valid_o = busy_q;
  assign digit       = bcd_q[idx_q*4 +: 4];
  assign out_digit_o = btda_pkg::ASCII_ZERO + {2'b00, digit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= head_i.top;
    end else if (xfer) begin
      if (out_last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bcd_q <= head_i.bcd;
    end
  end

endmodule

/* hw/rtl/btda_checker.sv */
// Port-level checks for binary_to_decimal_ascii, attached by the bind below.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module btda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic first_q;

  // Track whether the next digit opens a new number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      first_q <= m_axis_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd57))
    else $error("output is not an ASCII decimal digit");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && first_q && !m_axis_tlast |-> m_axis_tdata != 8'd48)
    else $error("leading zero sent");

endmodule

bind binary_to_decimal_ascii btda_checker u_btda_checker (.*);
